// File: hw/rtl/parton_density_du_correction_defines.svh
// Assertion macros for the d/u density correction block.
// Included by files that check their own logic; depends on nothing else.
`ifndef PARTON_DENSITY_DU_CORRECTION_DEFINES_SVH
`define PARTON_DENSITY_DU_CORRECTION_DEFINES_SVH
`ifndef SYNTHESIS
`define PDC_ASSERT_IMP(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("pdc check failed");
`define PDC_ASSERT_NXT(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("pdc check failed");
`else
`define PDC_ASSERT_IMP(lbl, clk, rst_n, a, b)
`define PDC_ASSERT_NXT(lbl, clk, rst_n, a, b)
`endif
`endif

// File: hw/rtl/pdc_pkg.sv
// Shared types, constants and fixed-point helpers of the d/u density correction.
// Used by every module of the block; depends on nothing.
package pdc_pkg;

  localparam int FRAC_BITS = 24;
  localparam int WORD_BITS = 32;
  localparam int PROD_W    = 2 * WORD_BITS;
  localparam int MAG_W     = PROD_W + 1;
  localparam int X_W       = FRAC_BITS + 1;
  localparam int NUM_W     = WORD_BITS + FRAC_BITS;
  localparam int DIV_LAT   = NUM_W + 2;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);
  localparam int CFG_IDX_W = 3;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [PROD_W-1:0]    prod_t;
  typedef logic        [MAG_W-1:0]     mag_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELTA_C0     = CFG_IDX_W'(0),
    REG_DELTA_C1     = CFG_IDX_W'(1),
    REG_DELTA_C2     = CFG_IDX_W'(2),
    REG_UP_SEA_SCALE = CFG_IDX_W'(3),
    REG_DN_SEA_SCALE = CFG_IDX_W'(4),
    REG_DELTA_ENABLE = CFG_IDX_W'(5)
  } cfg_reg_t;

  typedef struct packed {
    word_t delta_c0;
    word_t delta_c1;
    word_t delta_c2;
    word_t up_sea_scale;
    word_t down_sea_scale;
    logic  delta_enable;
  } cfg_t;

  typedef struct packed {
    logic [X_W-1:0] bjorken_x;
    word_t          up_valence_in;
    word_t          down_valence_in;
    word_t          up_sea_in;
    word_t          down_sea_in;
  } in_item_t;

  typedef struct packed {
    word_t up_valence_out;
    word_t down_valence_out;
    word_t up_sea_out;
    word_t down_sea_out;
    logic  range_error;
  } out_item_t;

  typedef struct packed {
    logic  err;
    word_t val;
  } sat_t;

  typedef struct packed {
    logic vld;
    logic push;
  } front_stat_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  localparam word_t W_MAX   = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t W_MIN   = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam mag_t  LIM_POS = {{(MAG_W-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
  localparam mag_t  LIM_NEG = LIM_POS + mag_t'(1);
  localparam mag_t  RND     = mag_t'(1) << (FRAC_BITS - 1);
  localparam word_t ONE     = (FRAC_BITS < WORD_BITS - 1) ? (word_t'(1) << FRAC_BITS) : W_MAX;

  function automatic sat_t sat_mag(input logic neg, input mag_t m);
    sat_t s;
    s.err = 1'b0;
    if (neg) begin
      if (m > LIM_NEG) begin
        s.err = 1'b1;
        s.val = W_MIN;
      end else begin
        s.val = word_t'(mag_t'(0) - m);
      end
    end else begin
      if (m > LIM_POS) begin
        s.err = 1'b1;
        s.val = W_MAX;
      end else begin
        s.val = word_t'(m);
      end
    end
    return s;
  endfunction

  function automatic sat_t add_sat(input word_t a, input word_t b, input logic sub);
    logic signed [WORD_BITS:0] sm;
    sat_t s;
    sm = sub ? ({a[WORD_BITS-1], a} - {b[WORD_BITS-1], b})
             : ({a[WORD_BITS-1], a} + {b[WORD_BITS-1], b});
    s.err = (sm[WORD_BITS] != sm[WORD_BITS-1]);
    if (s.err) begin
      s.val = sm[WORD_BITS] ? W_MIN : W_MAX;
    end else begin
      s.val = sm[WORD_BITS-1:0];
    end
    return s;
  endfunction

  function automatic sat_t round_prod(input prod_t p);
    logic              neg;
    logic [PROD_W-1:0] m;
    mag_t              r;
    neg = p[PROD_W-1];
    m   = neg ? (PROD_W'(0) - p) : p;
    r   = (mag_t'(m) + RND) >> FRAC_BITS;
    return sat_mag(neg, r);
  endfunction

endpackage

// File: hw/rtl/parton_density_du_correction.sv
// Top level of the d/u density correction: register bank, front end, queue, back end.
// Depends on pdc_pkg, pdc_front, pdc_queue, pdc_back and the defines header.
//
//  channel | signals                          | beat taken when
//  --------+----------------------------------+--------------------------
//  in      | in_valid, in_stall, in_data      | in_valid && !in_stall
//  out     | out_valid, out_stall, out_data   | out_valid && !out_stall
//  cfg     | cfg_we, cfg_index, cfg_wdata     | cfg_we
//
// One item per cycle sustained while the output is not stalled; data words are Q8.24, and
// the arithmetic runs through two rows of one-bit-per-stage dividers (NUM_W stages each).
// Reset is synchronous on rst_n; no clearing pass.
// A stalled output freezes the back end as a whole; the 4-deep queue and the input
// register absorb the front side until the queue fills.
`include "parton_density_du_correction_defines.svh"
module parton_density_du_correction (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  pdc_pkg::in_item_t                    in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output pdc_pkg::out_item_t                   out_data,
  input  logic                                 cfg_we,
  input  logic [pdc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pdc_pkg::WORD_BITS-1:0]        cfg_wdata
);

  pdc_pkg::cfg_t         cfg_r;
  pdc_pkg::in_item_t     f_item, q_head;
  pdc_pkg::front_stat_t  fst;
  pdc_pkg::queue_stat_t  qst;
  logic                  q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.delta_c0       <= '0;
      cfg_r.delta_c1       <= '0;
      cfg_r.delta_c2       <= '0;
      cfg_r.up_sea_scale   <= '0;
      cfg_r.down_sea_scale <= '0;
      cfg_r.delta_enable   <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pdc_pkg::REG_DELTA_C0:     cfg_r.delta_c0       <= cfg_wdata;
        pdc_pkg::REG_DELTA_C1:     cfg_r.delta_c1       <= cfg_wdata;
        pdc_pkg::REG_DELTA_C2:     cfg_r.delta_c2       <= cfg_wdata;
        pdc_pkg::REG_UP_SEA_SCALE: cfg_r.up_sea_scale   <= cfg_wdata;
        pdc_pkg::REG_DN_SEA_SCALE: cfg_r.down_sea_scale <= cfg_wdata;
        pdc_pkg::REG_DELTA_ENABLE: cfg_r.delta_enable   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  pdc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full_i (qst.full),
    .item_o   (f_item),
    .fst_o    (fst)
  );

  pdc_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_i (fst.push),
    .item_i (f_item),
    .pop_i  (q_pop),
    .head_o (q_head),
    .qst_o  (qst)
  );

  pdc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_i     (cfg_r),
    .q_vld_i   (!qst.empty),
    .q_item_i  (q_head),
    .q_pop_o   (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  `PDC_ASSERT_IMP(a_no_push_full, clk, rst_n, fst.push, !qst.full)
  `PDC_ASSERT_IMP(a_no_pop_empty, clk, rst_n, q_pop, !qst.empty)
  `PDC_ASSERT_NXT(a_front_holds, clk, rst_n, fst.vld && qst.full && !q_pop, fst.vld)

endmodule

// File: hw/rtl/pdc_div.sv
// Pipelined restoring divider: round(n * 2^FRAC_BITS / d), ties away from zero, saturated.
// One quotient bit per stage; depends on pdc_pkg.
module pdc_div (
  input  logic              clk,
  input  logic              en,
  input  pdc_pkg::word_t    num_i,
  input  pdc_pkg::word_t    den_i,
  output pdc_pkg::word_t    quo_o,
  output logic              err_o
);

  logic [pdc_pkg::WORD_BITS-1:0] nmag_r, dmag_r, nmag_nxt, dmag_nxt;
  logic                          neg_e_r;

  logic [pdc_pkg::WORD_BITS-1:0] rem_r   [pdc_pkg::NUM_W];
  logic [pdc_pkg::NUM_W-1:0]     dq_r    [pdc_pkg::NUM_W];
  logic [pdc_pkg::WORD_BITS-1:0] dsr_r   [pdc_pkg::NUM_W];
  logic                          sgn_r   [pdc_pkg::NUM_W];
  logic [pdc_pkg::WORD_BITS-1:0] rem_in  [pdc_pkg::NUM_W];
  logic [pdc_pkg::NUM_W-1:0]     dq_in   [pdc_pkg::NUM_W];
  logic [pdc_pkg::WORD_BITS-1:0] dsr_in  [pdc_pkg::NUM_W];
  logic                          sgn_in  [pdc_pkg::NUM_W];
  logic [pdc_pkg::WORD_BITS-1:0] rem_nxt [pdc_pkg::NUM_W];
  logic [pdc_pkg::NUM_W-1:0]     dq_nxt  [pdc_pkg::NUM_W];

  pdc_pkg::word_t quo_r;
  logic           err_r;
  logic           rnd_up;
  pdc_pkg::mag_t  qmag;
  pdc_pkg::sat_t  qsat;

  assign nmag_nxt = num_i[pdc_pkg::WORD_BITS-1] ? (pdc_pkg::WORD_BITS'(0) - num_i) : num_i;
  assign dmag_nxt = den_i[pdc_pkg::WORD_BITS-1] ? (pdc_pkg::WORD_BITS'(0) - den_i) : den_i;

  always_ff @(posedge clk) begin
    if (en) begin
      nmag_r  <= nmag_nxt;
      dmag_r  <= dmag_nxt;
      neg_e_r <= num_i[pdc_pkg::WORD_BITS-1] ^ den_i[pdc_pkg::WORD_BITS-1];
    end
  end

  genvar k;
  generate
    for (k = 0; k < pdc_pkg::NUM_W; k++) begin : g_stage
      if (k == 0) begin : g_first
        assign rem_in[k] = '0;
        assign dq_in[k]  = {nmag_r, {pdc_pkg::FRAC_BITS{1'b0}}};
        assign dsr_in[k] = dmag_r;
        assign sgn_in[k] = neg_e_r;
      end else begin : g_next
        assign rem_in[k] = rem_r[k-1];
        assign dq_in[k]  = dq_r[k-1];
        assign dsr_in[k] = dsr_r[k-1];
        assign sgn_in[k] = sgn_r[k-1];
      end
    end
  endgenerate

  always_comb begin
    logic [pdc_pkg::WORD_BITS:0] t;
    logic [pdc_pkg::WORD_BITS:0] diff;
    logic                        ge;
    for (int i = 0; i < pdc_pkg::NUM_W; i++) begin
      t          = {rem_in[i], dq_in[i][pdc_pkg::NUM_W-1]};
      diff       = t - {1'b0, dsr_in[i]};
      ge         = (t >= {1'b0, dsr_in[i]});
      rem_nxt[i] = ge ? diff[pdc_pkg::WORD_BITS-1:0] : t[pdc_pkg::WORD_BITS-1:0];
      dq_nxt[i]  = {dq_in[i][pdc_pkg::NUM_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < pdc_pkg::NUM_W; i++) begin
        rem_r[i] <= rem_nxt[i];
        dq_r[i]  <= dq_nxt[i];
        dsr_r[i] <= dsr_in[i];
        sgn_r[i] <= sgn_in[i];
      end
    end
  end

  assign rnd_up = ({rem_r[pdc_pkg::NUM_W-1], 1'b0} >= {1'b0, dsr_r[pdc_pkg::NUM_W-1]});
  assign qmag   = pdc_pkg::mag_t'(dq_r[pdc_pkg::NUM_W-1]) + pdc_pkg::mag_t'(rnd_up);
  assign qsat   = pdc_pkg::sat_mag(sgn_r[pdc_pkg::NUM_W-1], qmag);

  always_ff @(posedge clk) begin
    if (en) begin
      quo_r <= qsat.val;
      err_r <= qsat.err;
    end
  end

  assign quo_o = quo_r;
  assign err_o = err_r;

endmodule

// File: hw/rtl/pdc_front.sv
// Front end: input register that takes beats and hands them to the queue.
// Depends on pdc_pkg.
module pdc_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  pdc_pkg::in_item_t     in_data,
  input  logic                  q_full_i,
  output pdc_pkg::in_item_t     item_o,
  output pdc_pkg::front_stat_t  fst_o
);

  logic              vld_r, vld_nxt;
  pdc_pkg::in_item_t item_r;
  logic              take, push;

  assign in_stall = vld_r && q_full_i;
  assign take     = in_valid && !in_stall;
  assign push     = vld_r && !q_full_i;

  always_comb begin
    vld_nxt = vld_r;
    if (take) begin
      vld_nxt = 1'b1;
    end else if (push) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= in_data;
    end
  end

  assign item_o     = item_r;
  assign fst_o.vld  = vld_r;
  assign fst_o.push = push;

endmodule

// File: hw/rtl/pdc_queue.sv
// Short FIFO between the front end and the arithmetic back end.
// Depends on pdc_pkg.
module pdc_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push_i,
  input  pdc_pkg::in_item_t     item_i,
  input  logic                  pop_i,
  output pdc_pkg::in_item_t     head_o,
  output pdc_pkg::queue_stat_t  qst_o
);

  pdc_pkg::in_item_t          mem_r [pdc_pkg::QDEPTH];
  logic [pdc_pkg::QPTR_W-1:0] wp_r, rp_r;
  logic [pdc_pkg::QCNT_W-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push_i) begin
        wp_r <= wp_r + pdc_pkg::QPTR_W'(1);
      end
      if (pop_i) begin
        rp_r <= rp_r + pdc_pkg::QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_r <= cnt_r + pdc_pkg::QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_r <= cnt_r - pdc_pkg::QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wp_r] <= item_i;
    end
  end

  assign head_o      = mem_r[rp_r];
  assign qst_o.full  = (cnt_r == pdc_pkg::QCNT_W'(pdc_pkg::QDEPTH));
  assign qst_o.empty = (cnt_r == '0);

endmodule

// File: hw/rtl/pdc_back.sv
// Back end: sea shift, delta polynomial, ratios and pair correction in one stall-as-a-whole pipe.
// Depends on pdc_pkg and pdc_div.
module pdc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  pdc_pkg::cfg_t       cfg_i,
  input  logic                q_vld_i,
  input  pdc_pkg::in_item_t   q_item_i,
  output logic                q_pop_o,
  output logic                out_valid,
  input  logic                out_stall,
  output pdc_pkg::out_item_t  out_data
);

  typedef struct packed {
    pdc_pkg::word_t uv;
    pdc_pkg::word_t dv;
    pdc_pkg::word_t us;
    pdc_pkg::word_t ds;
    pdc_pkg::word_t delta;
    logic           err;
    logic           zv;
    logic           zs;
  } side1_t;

  typedef struct packed {
    logic err;
    logic env;
    logic ens;
    logic zdv;
    logic zds;
  } side2_t;

  logic en, pop;

  // stage 1
  logic v1_r;
  pdc_pkg::word_t uv1_r, dv1_r, us1_r, ds1_r;
  pdc_pkg::prod_t pu1_r, pd1_r, pxx1_r, pc11_r;
  logic [2*pdc_pkg::X_W-1:0] xsq;
  logic signed [pdc_pkg::X_W:0] xs;
  // stage 2
  logic v2_r;
  pdc_pkg::word_t uv2_r, dv2_r, us2_r, ds2_r, pu2_r, pd2_r, xx2_r, c12_r;
  logic err2_r, ed2_r;
  pdc_pkg::sat_t ru, rd, rxx, rc1;
  // stage 3
  logic v3_r;
  pdc_pkg::word_t uv3_r, dv3_r, tu3_r, td3_r, us3_r, ds3_r, d13_r;
  pdc_pkg::prod_t pc23_r;
  logic err3_r, ed3_r;
  pdc_pkg::sat_t atu, atd, aus, ads, ad1;
  // stage 4
  logic v4_r;
  pdc_pkg::word_t uv4_r, dv4_r, us4_r, ds4_r, d14_r, c2x4_r;
  logic err4_r, ed4_r;
  pdc_pkg::sat_t auv, adv, rc2;
  // stage 5
  logic v5_r;
  pdc_pkg::word_t uv5_r, dv5_r, us5_r, ds5_r, val5_r, sea5_r, delta5_r;
  logic err5_r, zv5_r, zs5_r;
  pdc_pkg::sat_t aval, asea, adl;
  // first divider row
  pdc_pkg::word_t qrv, qrs;
  logic           erv, ers;
  side1_t sd1_r [pdc_pkg::DIV_LAT];
  logic   sv1_r [pdc_pkg::DIV_LAT];
  side1_t sd1;
  pdc_pkg::word_t rv, rs;
  // stage 7
  logic v7_r;
  pdc_pkg::word_t uv7_r, dv7_r, us7_r, ds7_r;
  pdc_pkg::prod_t pdv7_r, pds7_r, puv7_r, pus7_r;
  logic err7_r;
  // stage 8
  logic v8_r;
  pdc_pkg::word_t uv8_r, dv8_r, us8_r, ds8_r, drv8_r, drs8_r, udv8_r, uds8_r;
  logic err8_r, env8_r, ens8_r;
  pdc_pkg::sat_t rdv, rds, ruv, rus;
  // stage 9
  logic v9_r;
  pdc_pkg::word_t uv9_r, nv9_r, denv9_r, us9_r, ns9_r, dens9_r;
  logic err9_r, env9_r, ens9_r, zdv9_r, zds9_r;
  pdc_pkg::sat_t adenv, adens, anv, ans;
  // second divider row
  pdc_pkg::word_t quv, qdv, qus, qds;
  logic           euv, edv, eus, eds;
  side2_t sd2_r [pdc_pkg::DIV_LAT];
  logic   sv2_r [pdc_pkg::DIV_LAT];
  side2_t sd2;
  // output
  logic               out_vld_r;
  pdc_pkg::out_item_t out_r, out_nxt;

  assign en      = !(out_vld_r && out_stall);
  assign pop     = en && q_vld_i;
  assign q_pop_o = pop;

  assign xsq = {{pdc_pkg::X_W{1'b0}}, q_item_i.bjorken_x}
             * {{pdc_pkg::X_W{1'b0}}, q_item_i.bjorken_x};
  assign xs  = $signed({1'b0, q_item_i.bjorken_x});

  always_ff @(posedge clk) begin
    if (en) begin
      uv1_r  <= q_item_i.up_valence_in;
      dv1_r  <= q_item_i.down_valence_in;
      us1_r  <= q_item_i.up_sea_in;
      ds1_r  <= q_item_i.down_sea_in;
      pu1_r  <= cfg_i.up_sea_scale * q_item_i.up_sea_in;
      pd1_r  <= cfg_i.down_sea_scale * q_item_i.down_sea_in;
      pxx1_r <= pdc_pkg::prod_t'(xsq);
      pc11_r <= cfg_i.delta_c1 * xs;
    end
  end

  assign ru  = pdc_pkg::round_prod(pu1_r);
  assign rd  = pdc_pkg::round_prod(pd1_r);
  assign rxx = pdc_pkg::round_prod(pxx1_r);
  assign rc1 = pdc_pkg::round_prod(pc11_r);

  always_ff @(posedge clk) begin
    if (en) begin
      uv2_r  <= uv1_r;
      dv2_r  <= dv1_r;
      us2_r  <= us1_r;
      ds2_r  <= ds1_r;
      pu2_r  <= ru.val;
      pd2_r  <= rd.val;
      xx2_r  <= rxx.val;
      c12_r  <= rc1.val;
      err2_r <= ru.err | rd.err;
      ed2_r  <= rxx.err | rc1.err;
    end
  end

  assign atu = pdc_pkg::add_sat(pu2_r, pu2_r, 1'b0);
  assign atd = pdc_pkg::add_sat(pd2_r, pd2_r, 1'b0);
  assign aus = pdc_pkg::add_sat(us2_r, pu2_r, 1'b0);
  assign ads = pdc_pkg::add_sat(ds2_r, pd2_r, 1'b0);
  assign ad1 = pdc_pkg::add_sat(cfg_i.delta_c0, c12_r, 1'b0);

  always_ff @(posedge clk) begin
    if (en) begin
      uv3_r  <= uv2_r;
      dv3_r  <= dv2_r;
      tu3_r  <= atu.val;
      td3_r  <= atd.val;
      us3_r  <= aus.val;
      ds3_r  <= ads.val;
      d13_r  <= ad1.val;
      pc23_r <= cfg_i.delta_c2 * xx2_r;
      err3_r <= err2_r | atu.err | atd.err | aus.err | ads.err;
      ed3_r  <= ed2_r | ad1.err;
    end
  end

  assign auv = pdc_pkg::add_sat(uv3_r, tu3_r, 1'b1);
  assign adv = pdc_pkg::add_sat(dv3_r, td3_r, 1'b1);
  assign rc2 = pdc_pkg::round_prod(pc23_r);

  always_ff @(posedge clk) begin
    if (en) begin
      uv4_r  <= auv.val;
      dv4_r  <= adv.val;
      us4_r  <= us3_r;
      ds4_r  <= ds3_r;
      d14_r  <= d13_r;
      c2x4_r <= rc2.val;
      err4_r <= err3_r | auv.err | adv.err;
      ed4_r  <= ed3_r | rc2.err;
    end
  end

  assign aval = pdc_pkg::add_sat(uv4_r, dv4_r, 1'b0);
  assign asea = pdc_pkg::add_sat(us4_r, ds4_r, 1'b0);
  assign adl  = pdc_pkg::add_sat(d14_r, c2x4_r, 1'b0);

  always_ff @(posedge clk) begin
    if (en) begin
      uv5_r    <= uv4_r;
      dv5_r    <= dv4_r;
      us5_r    <= us4_r;
      ds5_r    <= ds4_r;
      val5_r   <= aval.val;
      sea5_r   <= asea.val;
      delta5_r <= cfg_i.delta_enable ? adl.val : '0;
      zv5_r    <= (aval.val == '0);
      zs5_r    <= (asea.val == '0);
      err5_r   <= err4_r | aval.err | asea.err | (cfg_i.delta_enable & (ed4_r | adl.err))
                | (aval.val == '0) | (asea.val == '0);
    end
  end

  pdc_div u_div_rv (.clk(clk), .en(en), .num_i(uv5_r), .den_i(val5_r), .quo_o(qrv), .err_o(erv));
  pdc_div u_div_rs (.clk(clk), .en(en), .num_i(us5_r), .den_i(sea5_r), .quo_o(qrs), .err_o(ers));

  always_ff @(posedge clk) begin
    if (en) begin
      sd1_r[0] <= '{uv: uv5_r, dv: dv5_r, us: us5_r, ds: ds5_r, delta: delta5_r,
                    err: err5_r, zv: zv5_r, zs: zs5_r};
      for (int i = 1; i < pdc_pkg::DIV_LAT; i++) begin
        sd1_r[i] <= sd1_r[i-1];
      end
    end
  end

  assign sd1 = sd1_r[pdc_pkg::DIV_LAT-1];
  assign rv  = sd1.zv ? '0 : qrv;
  assign rs  = sd1.zs ? '0 : qrs;

  always_ff @(posedge clk) begin
    if (en) begin
      uv7_r  <= sd1.uv;
      dv7_r  <= sd1.dv;
      us7_r  <= sd1.us;
      ds7_r  <= sd1.ds;
      pdv7_r <= sd1.delta * rv;
      pds7_r <= sd1.delta * rs;
      puv7_r <= sd1.uv * sd1.delta;
      pus7_r <= sd1.us * sd1.delta;
      err7_r <= sd1.err | (!sd1.zv & erv) | (!sd1.zs & ers);
    end
  end

  assign rdv = pdc_pkg::round_prod(pdv7_r);
  assign rds = pdc_pkg::round_prod(pds7_r);
  assign ruv = pdc_pkg::round_prod(puv7_r);
  assign rus = pdc_pkg::round_prod(pus7_r);

  always_ff @(posedge clk) begin
    if (en) begin
      uv8_r  <= uv7_r;
      dv8_r  <= dv7_r;
      us8_r  <= us7_r;
      ds8_r  <= ds7_r;
      drv8_r <= rdv.val;
      drs8_r <= rds.val;
      udv8_r <= ruv.val;
      uds8_r <= rus.val;
      err8_r <= err7_r | rdv.err | rds.err;
      env8_r <= ruv.err;
      ens8_r <= rus.err;
    end
  end

  assign adenv = pdc_pkg::add_sat(pdc_pkg::ONE, drv8_r, 1'b0);
  assign adens = pdc_pkg::add_sat(pdc_pkg::ONE, drs8_r, 1'b0);
  assign anv   = pdc_pkg::add_sat(dv8_r, udv8_r, 1'b0);
  assign ans   = pdc_pkg::add_sat(ds8_r, uds8_r, 1'b0);

  always_ff @(posedge clk) begin
    if (en) begin
      uv9_r   <= uv8_r;
      us9_r   <= us8_r;
      nv9_r   <= anv.val;
      ns9_r   <= ans.val;
      denv9_r <= adenv.val;
      dens9_r <= adens.val;
      err9_r  <= err8_r | adenv.err | adens.err;
      env9_r  <= env8_r | anv.err;
      ens9_r  <= ens8_r | ans.err;
      zdv9_r  <= (adenv.val == '0);
      zds9_r  <= (adens.val == '0);
    end
  end

  pdc_div u_div_uv (.clk(clk), .en(en), .num_i(uv9_r), .den_i(denv9_r), .quo_o(quv), .err_o(euv));
  pdc_div u_div_dv (.clk(clk), .en(en), .num_i(nv9_r), .den_i(denv9_r), .quo_o(qdv), .err_o(edv));
  pdc_div u_div_us (.clk(clk), .en(en), .num_i(us9_r), .den_i(dens9_r), .quo_o(qus), .err_o(eus));
  pdc_div u_div_ds (.clk(clk), .en(en), .num_i(ns9_r), .den_i(dens9_r), .quo_o(qds), .err_o(eds));

  always_ff @(posedge clk) begin
    if (en) begin
      sd2_r[0] <= '{err: err9_r, env: env9_r, ens: ens9_r, zdv: zdv9_r, zds: zds9_r};
      for (int i = 1; i < pdc_pkg::DIV_LAT; i++) begin
        sd2_r[i] <= sd2_r[i-1];
      end
    end
  end

  assign sd2 = sd2_r[pdc_pkg::DIV_LAT-1];

  always_comb begin
    out_nxt.up_valence_out   = sd2.zdv ? '0 : quv;
    out_nxt.down_valence_out = sd2.zdv ? '0 : qdv;
    out_nxt.up_sea_out       = sd2.zds ? '0 : qus;
    out_nxt.down_sea_out     = sd2.zds ? '0 : qds;
    out_nxt.range_error      = sd2.err | sd2.zdv | sd2.zds
                             | (!sd2.zdv & (sd2.env | euv | edv))
                             | (!sd2.zds & (sd2.ens | eus | eds));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  // advance valid bits with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      v3_r      <= 1'b0;
      v4_r      <= 1'b0;
      v5_r      <= 1'b0;
      v7_r      <= 1'b0;
      v8_r      <= 1'b0;
      v9_r      <= 1'b0;
      out_vld_r <= 1'b0;
      for (int i = 0; i < pdc_pkg::DIV_LAT; i++) begin
        sv1_r[i] <= 1'b0;
        sv2_r[i] <= 1'b0;
      end
    end else if (en) begin
      v1_r      <= pop;
      v2_r      <= v1_r;
      v3_r      <= v2_r;
      v4_r      <= v3_r;
      v5_r      <= v4_r;
      sv1_r[0]  <= v5_r;
      v7_r      <= sv1_r[pdc_pkg::DIV_LAT-1];
      v8_r      <= v7_r;
      v9_r      <= v8_r;
      sv2_r[0]  <= v9_r;
      out_vld_r <= sv2_r[pdc_pkg::DIV_LAT-1];
      for (int i = 1; i < pdc_pkg::DIV_LAT; i++) begin
        sv1_r[i] <= sv1_r[i-1];
        sv2_r[i] <= sv2_r[i-1];
      end
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

// File: tb/tb.sv
// Self-checking bench for the d/u density correction block.
// Streams directed and random items under several register settings and checks each
// result against a bit-exact fixed-point predictor; depends on pdc_pkg and the RTL.
module tb;
  import pdc_pkg::*;

  typedef logic signed [127:0] big_t;

  localparam big_t BIG_MAX = big_t'(64'sh7fffffff);
  localparam big_t BIG_MIN = -big_t'(64'sh80000000);
  localparam big_t BIG_ONE = big_t'(64'sh1000000);
  localparam int   DRAIN_CYCLES = 140;
  localparam int   CYCLE_LIMIT  = 400000;
  localparam int   HOLD_CYCLES  = 400;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_data;
  logic       cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [WORD_BITS-1:0] cfg_wdata = '0;

  big_t coef_c0, coef_c1, coef_c2, scale_up, scale_dn;
  bit   delta_on;

  in_item_t  pending_items[$];
  out_item_t expected_results[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int hold_cnt = 0;
  int mismatches = 0;
  int results_seen = 0;
  int items_sent = 0;
  int settings_used = 0;
  int cycles = 0;

  parton_density_du_correction u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic big_t clamp_word(big_t v, inout bit e);
    if (v > BIG_MAX) begin
      e = 1'b1;
      return BIG_MAX;
    end
    if (v < BIG_MIN) begin
      e = 1'b1;
      return BIG_MIN;
    end
    return v;
  endfunction

  function automatic big_t add_q(big_t a, big_t b, inout bit e);
    return clamp_word(a + b, e);
  endfunction

  function automatic big_t mul_q(big_t a, big_t b, inout bit e);
    big_t p, m;
    p = a * b;
    m = (p < 0) ? -p : p;
    m = (m + (big_t'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    return clamp_word((p < 0) ? -m : m, e);
  endfunction

  function automatic big_t div_q(big_t n, big_t d, inout bit e);
    big_t un, ud, q;
    un = (n < 0) ? -n : n;
    ud = (d < 0) ? -d : d;
    q = ((un <<< (FRAC_BITS + 1)) + ud) / (ud <<< 1);
    return clamp_word(((n < 0) != (d < 0)) ? -q : q, e);
  endfunction

  function automatic void correct_pair(big_t u, big_t d, big_t r, big_t delta,
                                       output word_t ou, output word_t od, inout bit e);
    big_t den;
    den = add_q(BIG_ONE, mul_q(delta, r, e), e);
    if (den == 0) begin
      e = 1'b1;
      ou = '0;
      od = '0;
    end else begin
      ou = word_t'(div_q(u, den, e));
      od = word_t'(div_q(add_q(d, mul_q(u, delta, e), e), den, e));
    end
  endfunction

  function automatic out_item_t corrected_densities(in_item_t it);
    out_item_t res;
    bit e;
    big_t x, uv, dv, us, ds, p, delta, val_sum, sea_sum, rv, rs;
    e = 1'b0;
    x  = big_t'(it.bjorken_x);
    uv = big_t'(it.up_valence_in);
    dv = big_t'(it.down_valence_in);
    us = big_t'(it.up_sea_in);
    ds = big_t'(it.down_sea_in);
    p  = mul_q(scale_up, us, e);
    uv = clamp_word(uv - add_q(p, p, e), e);
    p  = mul_q(scale_dn, ds, e);
    dv = clamp_word(dv - add_q(p, p, e), e);
    us = add_q(us, mul_q(us, scale_up, e), e);
    ds = add_q(ds, mul_q(ds, scale_dn, e), e);
    delta = 0;
    if (delta_on) begin
      p = mul_q(x, x, e);
      delta = add_q(coef_c0, mul_q(coef_c1, x, e), e);
      delta = add_q(delta, mul_q(coef_c2, p, e), e);
    end
    val_sum = add_q(uv, dv, e);
    sea_sum = add_q(us, ds, e);
    rv = 0;
    rs = 0;
    if (val_sum == 0) e = 1'b1; else rv = div_q(uv, val_sum, e);
    if (sea_sum == 0) e = 1'b1; else rs = div_q(us, sea_sum, e);
    correct_pair(uv, dv, rv, delta, res.up_valence_out, res.down_valence_out, e);
    correct_pair(us, ds, rs, delta, res.up_sea_out, res.down_sea_out, e);
    res.range_error = e;
    return res;
  endfunction

  // driver: advance on each accepted beat
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(corrected_densities(in_data));
        items_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall, with one long hold to back the block up
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_cnt <= hold_cnt + 1;
      if (hold_cnt >= HOLD_CYCLES) hold_done <= 1'b1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %h", out_data);
      end else begin
        want = expected_results.pop_front();
        if (want.up_valence_out !== out_data.up_valence_out ||
            want.down_valence_out !== out_data.down_valence_out ||
            want.up_sea_out !== out_data.up_sea_out ||
            want.down_sea_out !== out_data.down_sea_out ||
            want.range_error !== out_data.range_error) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: expected %h %h %h %h err %b, got %h %h %h %h err %b",
                     results_seen, want.up_valence_out, want.down_valence_out,
                     want.up_sea_out, want.down_sea_out, want.range_error,
                     out_data.up_valence_out, out_data.down_valence_out,
                     out_data.up_sea_out, out_data.down_sea_out, out_data.range_error);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic write_reg(cfg_reg_t idx, word_t v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_DELTA_C0:     coef_c0 = big_t'(v);
      REG_DELTA_C1:     coef_c1 = big_t'(v);
      REG_DELTA_C2:     coef_c2 = big_t'(v);
      REG_UP_SEA_SCALE: scale_up = big_t'(v);
      REG_DN_SEA_SCALE: scale_dn = big_t'(v);
      REG_DELTA_ENABLE: delta_on = v[0];
      default: ;
    endcase
  endtask

  task automatic drain();
    wait (pending_items.size() == 0 && !in_valid && expected_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic word_t pick_word(int style);
    case (style)
      0: return word_t'($urandom_range(0, 1 << 25)) - word_t'(1 << 24);
      1: return word_t'($urandom);
      default: begin
        case ($urandom_range(4))
          0: return W_MAX;
          1: return W_MIN;
          2: return '0;
          3: return word_t'(1);
          default: return -word_t'(1);
        endcase
      end
    endcase
  endfunction

  function automatic in_item_t make_item();
    in_item_t it;
    int r;
    r = $urandom_range(99);
    it.bjorken_x = ($urandom_range(9) == 0) ? X_W'($urandom) : X_W'($urandom_range(0, 1 << 24));
    it.up_valence_in   = (r < 85) ? pick_word(0) : pick_word(r < 93 ? 2 : 1);
    it.down_valence_in = (r < 85) ? pick_word(0) : pick_word(r < 93 ? 2 : 1);
    it.up_sea_in       = (r < 85) ? (pick_word(0) >>> 2) : pick_word(r < 93 ? 2 : 1);
    it.down_sea_in     = (r < 85) ? (pick_word(0) >>> 2) : pick_word(r < 93 ? 2 : 1);
    if (r >= 75 && r < 80) it.down_valence_in = -it.up_valence_in;
    if (r >= 80 && r < 85) it.down_sea_in = -it.up_sea_in;
    return it;
  endfunction

  function automatic in_item_t directed(logic [X_W-1:0] x, word_t uv, word_t dv,
                                        word_t us, word_t ds);
    in_item_t it;
    it.bjorken_x = x;
    it.up_valence_in = uv;
    it.down_valence_in = dv;
    it.up_sea_in = us;
    it.down_sea_in = ds;
    return it;
  endfunction

  initial begin
    int style;
    coef_c0 = 0;
    coef_c1 = 0;
    coef_c2 = 0;
    scale_up = 0;
    scale_dn = 0;
    delta_on = 1'b1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: extremes, zero sums, saturation
    pending_items.push_back(directed('0, ONE, ONE, ONE, ONE));
    pending_items.push_back(directed(X_W'(1 << 24), W_MAX, W_MAX, W_MAX, W_MAX));
    pending_items.push_back(directed(X_W'(1 << 24), W_MIN, W_MIN, W_MIN, W_MIN));
    pending_items.push_back(directed('0, '0, '0, '0, '0));
    pending_items.push_back(directed(X_W'(1 << 23), ONE, -ONE, ONE, -ONE));
    pending_items.push_back(directed('1, W_MAX, W_MIN, W_MIN, W_MAX));
    pending_items.push_back(directed(X_W'(3), word_t'(1), '0, -word_t'(1), '0));
    pending_items.push_back(directed(X_W'(1 << 24), word_t'(5), word_t'(7), word_t'(2),
                                     word_t'(9)));
    drain();

    // delta of minus one: zero correction denominator on pure up
    write_reg(REG_DELTA_C0, -ONE);
    write_reg(REG_DELTA_C1, '0);
    write_reg(REG_DELTA_C2, '0);
    settings_used++;
    pending_items.push_back(directed('0, ONE, '0, ONE, '0));
    pending_items.push_back(directed('0, word_t'(77), '0, ONE, ONE));
    pending_items.push_back(directed('1, ONE, ONE, word_t'(3), '0));
    drain();
    write_reg(REG_DELTA_C1, W_MAX);
    write_reg(REG_DELTA_C2, W_MIN);
    write_reg(REG_UP_SEA_SCALE, ONE);
    write_reg(REG_DN_SEA_SCALE, -ONE);
    settings_used++;
    pending_items.push_back(directed(X_W'(1 << 24), ONE, ONE, ONE, ONE));
    pending_items.push_back(directed(X_W'(1 << 22), W_MAX, W_MIN, W_MAX, W_MIN));
    pending_items.push_back(directed('1, -ONE, ONE, ONE, -ONE));
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      if (ph < 3) begin
        send_idle_pct = 23;
        recv_idle_pct = 45;
      end else if (ph < 6) begin
        send_idle_pct = 45;
        recv_idle_pct = 23;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      style = (ph == 2 || ph == 6) ? 2 : (ph == 4 ? 1 : 0);
      write_reg(REG_DELTA_C0, pick_word(style));
      write_reg(REG_DELTA_C1, pick_word(style));
      write_reg(REG_DELTA_C2, pick_word(style));
      write_reg(REG_UP_SEA_SCALE, (style == 0) ? (pick_word(0) >>> 3) : pick_word(style));
      write_reg(REG_DN_SEA_SCALE, (style == 0) ? (pick_word(0) >>> 3) : pick_word(style));
      write_reg(REG_DELTA_ENABLE, (ph == 3 || ph == 7) ? word_t'(0) : word_t'(1));
      settings_used++;
      for (int i = 0; i < ((ph == 1) ? 240 : 80); i++) pending_items.push_back(make_item());
      if (ph == 1) hold_req = 1'b1;
      drain();
    end

    $display("Streamed %0d items and checked %0d results across %0d register settings,",
             items_sent, results_seen, settings_used);
    $display("including zero sums, zero denominators, saturation and a long output hold.");
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_results.size());
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: parton_density_du_correction.f
+incdir+hw/rtl
hw/rtl/pdc_pkg.sv
hw/rtl/pdc_div.sv
hw/rtl/pdc_front.sv
hw/rtl/pdc_queue.sv
hw/rtl/pdc_back.sv
hw/rtl/parton_density_du_correction.sv
tb/tb.sv
